// File: rtl/i2c_master_event_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// I2C master event sequencer: assertion macros
// Shared property shapes for the port-level checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_EVENT_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_EVENT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication
`define IMES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IMES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/imes_pkg.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer package
// Operation codes, command, event and error bit positions, item, result and buffer-write types.
// ----------------------------------------------------------------------------
package imes_pkg;

  localparam int unsigned BufDepthDefault = 64;

  localparam logic [7:0] NoSubAddr = 8'hFF;

  typedef enum logic [2:0] {
    OP_WRITE_JOB   = 3'd0,
    OP_READ_JOB    = 3'd1,
    OP_LOAD        = 3'd2,
    OP_BUS_EVENT   = 3'd3,
    OP_ERROR_EVENT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    TX_NONE    = 2'd0,
    TX_ADDR_WR = 2'd1,
    TX_ADDR_RD = 2'd2,
    TX_DATA    = 2'd3
  } tx_kind_e;

  // Command bit positions in action_flags
  localparam int unsigned ActStart  = 0;
  localparam int unsigned ActStop   = 1;
  localparam int unsigned ActAckOn  = 2;
  localparam int unsigned ActAckOff = 3;
  localparam int unsigned ActPosSet = 4;
  localparam int unsigned ActPosClr = 5;
  localparam int unsigned ActBufOn  = 6;
  localparam int unsigned ActBufOff = 7;
  localparam int unsigned ActEvOn   = 8;
  localparam int unsigned ActEvOff  = 9;
  localparam int unsigned ActReinit = 10;

  // Event flag bit positions
  localparam int unsigned EvStartSent = 0;
  localparam int unsigned EvAddrSent  = 1;
  localparam int unsigned EvXferDone  = 2;
  localparam int unsigned EvRxFull    = 3;
  localparam int unsigned EvTxEmpty   = 4;

  // Error flag bit positions
  localparam int unsigned ErrBus = 0;
  localparam int unsigned ErrArb = 1;
  localparam int unsigned ErrAck = 2;
  localparam int unsigned ErrOvr = 3;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] dev_addr;
    logic [7:0] sub_addr;
    logic [6:0] length;
    logic [5:0] buffer_index;
    logic [7:0] data_byte;
    logic [7:0] data_byte_second;
    logic [4:0] event_flags;
    logic [3:0] error_flags;
    logic       start_pending;
    logic       stop_pending;
  } item_t;

  typedef struct packed {
    logic [10:0] action_flags;
    logic [1:0]  tx_kind;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [5:0]  rx_index;
    logic [7:0]  rx_byte;
    logic        job_accepted;
    logic        busy_res;
    logic        error;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } buf_wr_t;

endpackage

// File: rtl/imes_wbuf.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer: write buffer
// Single write port, one registered read port with write-first forwarding.
// ----------------------------------------------------------------------------
module imes_wbuf #(
  parameter int unsigned BUF_DEPTH = imes_pkg::BufDepthDefault
) (
  input  logic              clk_i,
  input  imes_pkg::buf_wr_t wr_i,
  input  logic [7:0]        rd_idx_i,
  output logic [7:0]        rd_data_o
);
  import imes_pkg::*;

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [6:0] Depth7 = 7'(BUF_DEPTH);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_q;
  logic [6:0] wr_addr7;
  logic       wr_ok;
  logic       rd_ok;

  assign wr_addr7 = {1'b0, wr_i.addr};
  assign wr_ok    = wr_i.en && (wr_addr7 < Depth7);
  assign rd_ok    = !rd_idx_i[7] && (rd_idx_i[6:0] < Depth7);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_addr7[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok && rd_ok && (wr_addr7 == rd_idx_i[6:0])) begin
      rd_data_q <= wr_i.data;
    end else if (rd_ok) begin
      rd_data_q <= mem[rd_idx_i[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/imes_core.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer: input stage and job state
// Holds the accepted item, updates the job state and forms the results.
// ----------------------------------------------------------------------------
module imes_core #(
  parameter int unsigned BUF_DEPTH = imes_pkg::BufDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  imes_pkg::item_t   item_i,
  input  logic              can_load_i,
  output logic              load_o,
  output imes_pkg::result_t r0_o,
  output imes_pkg::result_t r1_o,
  output logic              two_o,
  output imes_pkg::buf_wr_t wr_o,
  output logic [7:0]        rd_idx_o,
  input  logic [7:0]        rd_data_i
);
  import imes_pkg::*;

  localparam logic [6:0] Depth7 = 7'(BUF_DEPTH);

  logic       in_valid_q;
  item_t      item_q;
  logic       load;

  logic [6:0] target_addr_q, target_addr_d;
  logic [7:0] reg_addr_q, reg_addr_d;
  logic [6:0] job_length_q, job_length_d;
  logic       is_reading_q, is_reading_d;
  logic       is_writing_q, is_writing_d;
  logic       job_busy_q, job_busy_d;
  logic       job_error_q, job_error_d;
  logic       subaddr_done_q, subaddr_done_d;
  logic       final_stop_q, final_stop_d;
  logic [7:0] byte_index_q, byte_index_d;
  logic       event_irq_q, event_irq_d;

  logic [10:0] act;
  result_t     r0, r1;
  logic        two;
  logic [7:0]  i0, i1, i2, i3;
  logic        rdsub;
  logic [7:0]  len8;

  function automatic logic idx_in_range(input logic [7:0] idx);
    return !idx[7] && (idx[6:0] < Depth7);
  endfunction

  assign in_ready_o = !in_valid_q || can_load_i;
  assign load       = in_valid_q && can_load_i;
  assign load_o     = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign i0    = byte_index_q;
  assign i1    = byte_index_q + 8'd1;
  assign i2    = byte_index_q + 8'd2;
  assign i3    = byte_index_q + 8'd3;
  assign rdsub = is_reading_q && subaddr_done_q;
  assign len8  = {1'b0, job_length_q};

  always_comb begin
    target_addr_d  = target_addr_q;
    reg_addr_d     = reg_addr_q;
    job_length_d   = job_length_q;
    is_reading_d   = is_reading_q;
    is_writing_d   = is_writing_q;
    job_busy_d     = job_busy_q;
    job_error_d    = job_error_q;
    subaddr_done_d = subaddr_done_q;
    final_stop_d   = final_stop_q;
    byte_index_d   = byte_index_q;
    event_irq_d    = event_irq_q;
    act            = '0;
    r0             = '0;
    r1             = '0;
    two            = 1'b0;

    if (load) begin
      unique case (op_e'(item_q.operation))
        OP_WRITE_JOB, OP_READ_JOB: begin
          if (!job_busy_q) begin
            target_addr_d = item_q.dev_addr;
            reg_addr_d    = item_q.sub_addr;
            job_length_d  = item_q.length;
            is_writing_d  = (item_q.operation == OP_WRITE_JOB);
            is_reading_d  = (item_q.operation == OP_READ_JOB);
            job_busy_d    = 1'b1;
            job_error_d   = 1'b0;
            if (!event_irq_q) begin
              act[ActStart] = !item_q.start_pending;
              act[ActEvOn]  = 1'b1;
              event_irq_d   = 1'b1;
            end
            r0.job_accepted = 1'b1;
          end
        end
        OP_LOAD: begin
          // Buffer write goes through the memory port
        end
        OP_BUS_EVENT: begin
          if (item_q.event_flags[EvStartSent]) begin
            act[ActAckOn] = 1'b1;
            byte_index_d  = '0;
            if (is_reading_q && (subaddr_done_q || reg_addr_q == NoSubAddr)) begin
              subaddr_done_d = 1'b1;
              if (job_length_q == 7'd2) begin
                act[ActPosSet] = 1'b1;
              end else begin
                act[ActPosClr] = 1'b1;
              end
              r0.tx_kind = TX_ADDR_RD;
              r0.tx_byte = {target_addr_q, 1'b1};
            end else begin
              act[ActPosClr] = 1'b1;
              r0.tx_kind     = TX_ADDR_WR;
              r0.tx_byte     = {target_addr_q, 1'b0};
              // Sub-address goes out first: park the index one below zero
              if (reg_addr_q != NoSubAddr) begin
                byte_index_d = 8'hFF;
              end
            end
          end else if (item_q.event_flags[EvAddrSent]) begin
            if (job_length_q == 7'd1 && rdsub) begin
              act[ActAckOff] = 1'b1;
              act[ActStop]   = 1'b1;
              act[ActBufOn]  = 1'b1;
              final_stop_d   = 1'b1;
            end else if (job_length_q == 7'd2 && rdsub) begin
              act[ActAckOff] = 1'b1;
              act[ActBufOff] = 1'b1;
            end else if (job_length_q == 7'd3 && rdsub) begin
              act[ActBufOff] = 1'b1;
            end else begin
              act[ActBufOn] = 1'b1;
            end
          end else if (item_q.event_flags[EvXferDone]) begin
            final_stop_d = 1'b1;
            if (rdsub) begin
              if (job_length_q > 7'd2) begin
                act[ActAckOff] = 1'b1;
                act[ActStop]   = 1'b1;
                act[ActBufOn]  = 1'b1;
                byte_index_d   = i2;
              end else begin
                act[ActStop] = 1'b1;
                byte_index_d = i3;
              end
              r0.rx_valid = idx_in_range(i0);
              r0.rx_index = idx_in_range(i0) ? i0[5:0] : '0;
              r0.rx_byte  = idx_in_range(i0) ? item_q.data_byte : '0;
              r1.rx_valid = idx_in_range(i1);
              r1.rx_index = idx_in_range(i1) ? i1[5:0] : '0;
              r1.rx_byte  = idx_in_range(i1) ? item_q.data_byte_second : '0;
              two         = 1'b1;
            end else if (subaddr_done_q || is_writing_q) begin
              act[ActStop] = 1'b1;
              byte_index_d = i1;
            end else begin
              // Repeated start for the read phase
              act[ActStart]  = 1'b1;
              subaddr_done_d = 1'b1;
            end
          end else if (item_q.event_flags[EvRxFull]) begin
            r0.rx_valid = idx_in_range(i0);
            r0.rx_index = idx_in_range(i0) ? i0[5:0] : '0;
            r0.rx_byte  = idx_in_range(i0) ? item_q.data_byte : '0;
            if (len8 == i0 + 8'd4) begin
              act[ActBufOff] = 1'b1;
            end
            byte_index_d = (len8 == i1) ? i2 : i1;
          end else if (item_q.event_flags[EvTxEmpty]) begin
            r0.tx_kind = TX_DATA;
            if (i0 != 8'hFF) begin
              r0.tx_byte   = idx_in_range(i0) ? rd_data_i : '0;
              byte_index_d = i1;
              if (len8 == i1) begin
                act[ActBufOff] = 1'b1;
              end
            end else begin
              r0.tx_byte   = reg_addr_q;
              byte_index_d = '0;
              if (is_reading_q || job_length_q == 7'd0) begin
                act[ActBufOff] = 1'b1;
              end
            end
          end

          // Job complete once the index passes the length
          if ({byte_index_d[7], byte_index_d} == 9'({2'b00, job_length_q}) + 9'd1) begin
            subaddr_done_d = 1'b0;
            if (final_stop_d) begin
              act[ActEvOff] = 1'b1;
              event_irq_d   = 1'b0;
            end
            job_busy_d = 1'b0;
          end
        end
        OP_ERROR_EVENT: begin
          if (item_q.error_flags != '0) begin
            job_error_d = 1'b1;
          end
          if (item_q.error_flags[ErrAck:ErrBus] != '0) begin
            act[ActBufOff] = 1'b1;
            if (!item_q.error_flags[ErrArb] && !item_q.stop_pending) begin
              act[ActStop] = 1'b1;
              event_irq_d  = 1'b0;
              if (item_q.start_pending) begin
                act[ActReinit] = 1'b1;
                target_addr_d  = '0;
                reg_addr_d     = '0;
                job_length_d   = '0;
                is_reading_d   = 1'b0;
                is_writing_d   = 1'b0;
              end else begin
                act[ActEvOff] = 1'b1;
              end
            end
          end
          job_busy_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    r0.action_flags = act;
    r0.busy_res     = job_busy_d;
    r0.error        = job_error_d;
    r0.last         = !two;
    r1.busy_res     = job_busy_d;
    r1.error        = job_error_d;
    r1.last         = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_addr_q  <= '0;
      reg_addr_q     <= '0;
      job_length_q   <= '0;
      is_reading_q   <= 1'b0;
      is_writing_q   <= 1'b0;
      job_busy_q     <= 1'b0;
      job_error_q    <= 1'b0;
      subaddr_done_q <= 1'b0;
      final_stop_q   <= 1'b0;
      byte_index_q   <= '0;
      event_irq_q    <= 1'b0;
    end else begin
      target_addr_q  <= target_addr_d;
      reg_addr_q     <= reg_addr_d;
      job_length_q   <= job_length_d;
      is_reading_q   <= is_reading_d;
      is_writing_q   <= is_writing_d;
      job_busy_q     <= job_busy_d;
      job_error_q    <= job_error_d;
      subaddr_done_q <= subaddr_done_d;
      final_stop_q   <= final_stop_d;
      byte_index_q   <= byte_index_d;
      event_irq_q    <= event_irq_d;
    end
  end

  assign r0_o     = r0;
  assign r1_o     = r1;
  assign two_o    = two;
  assign rd_idx_o = byte_index_d;

  assign wr_o.en   = load && (item_q.operation == OP_LOAD);
  assign wr_o.addr = item_q.buffer_index;
  assign wr_o.data = item_q.data_byte;

endmodule

// File: rtl/imes_out.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer: result register
// Output register plus one pending slot for the second result of an item.
// ----------------------------------------------------------------------------
module imes_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  imes_pkg::result_t r0_i,
  input  imes_pkg::result_t r1_i,
  input  logic              two_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imes_pkg::result_t res_o
);
  import imes_pkg::*;

  logic    out_valid_q;
  logic    pend_valid_q;
  result_t out_q;
  result_t pend_q;
  logic    pop;

  assign pop        = out_valid_q && out_ready_i;
  assign can_load_o = !pend_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= two_i;
    end else if (pop) begin
      out_valid_q  <= pend_valid_q;
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q  <= r0_i;
      pend_q <= r1_i;
    end else if (pop && pend_valid_q) begin
      // Advance the second result into the output slot
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: rtl/i2c_master_event_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer
// Sequences an I2C master register read or write job from peripheral events.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): job requests, write-buffer loads,
// bus events and error events, one per transfer.
// Output channel (out_valid_o/out_ready_i): command flags, the byte to place
// in the data register, received bytes and busy/error status. A transfer-
// finished event in the read data phase gives two results; every other
// item gives one. last_o marks the final result of an item.
// An item passes through the input register, then the result register.
// Throughput: one item per cycle while results are taken; an item with two
// results holds the input while the second result goes out.
// A stalled receiver holds the result register and the pending second
// result; the input register keeps one further item, then in_ready_o drops.
// Reset clears the job state, flags and valid bits; the write buffer is not
// cleared, so a slot must be loaded before a job sends it.
// ----------------------------------------------------------------------------
module i2c_master_event_sequencer_top #(
  parameter int unsigned BUF_DEPTH = imes_pkg::BufDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [7:0]  sub_addr_i,
  input  logic [6:0]  length_i,
  input  logic [5:0]  buffer_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  data_byte_second_i,
  input  logic [4:0]  event_flags_i,
  input  logic [3:0]  error_flags_i,
  input  logic        start_pending_i,
  input  logic        stop_pending_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] action_flags_o,
  output logic [1:0]  tx_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        rx_valid_o,
  output logic [5:0]  rx_index_o,
  output logic [7:0]  rx_byte_o,
  output logic        job_accepted_o,
  output logic        busy_res_o,
  output logic        error_o,
  output logic        last_o
);
  import imes_pkg::*;

  item_t   item;
  result_t r0, r1, res;
  logic    two;
  logic    load;
  logic    can_load;
  buf_wr_t wr;
  logic [7:0] rd_idx;
  logic [7:0] rd_data;

  assign item.operation        = operation_i;
  assign item.dev_addr         = dev_addr_i;
  assign item.sub_addr         = sub_addr_i;
  assign item.length           = length_i;
  assign item.buffer_index     = buffer_index_i;
  assign item.data_byte        = data_byte_i;
  assign item.data_byte_second = data_byte_second_i;
  assign item.event_flags      = event_flags_i;
  assign item.error_flags      = error_flags_i;
  assign item.start_pending    = start_pending_i;
  assign item.stop_pending     = stop_pending_i;

  imes_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .can_load_i (can_load),
    .load_o     (load),
    .r0_o       (r0),
    .r1_o       (r1),
    .two_o      (two),
    .wr_o       (wr),
    .rd_idx_o   (rd_idx),
    .rd_data_i  (rd_data)
  );

  imes_wbuf #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_wbuf (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  imes_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .r0_i        (r0),
    .r1_i        (r1),
    .two_i       (two),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign action_flags_o = res.action_flags;
  assign tx_kind_o      = res.tx_kind;
  assign tx_byte_o      = res.tx_byte;
  assign rx_valid_o     = res.rx_valid;
  assign rx_index_o     = res.rx_index;
  assign rx_byte_o      = res.rx_byte;
  assign job_accepted_o = res.job_accepted;
  assign busy_res_o     = res.busy_res;
  assign error_o        = res.error;
  assign last_o         = res.last;

endmodule

// File: rtl/imes_checker.sv
// ----------------------------------------------------------------------------
// I2C master event sequencer: port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_event_sequencer_top_defines.svh"

module imes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  operation_i,
  input logic [6:0]  dev_addr_i,
  input logic [7:0]  sub_addr_i,
  input logic [6:0]  length_i,
  input logic [5:0]  buffer_index_i,
  input logic [7:0]  data_byte_i,
  input logic [7:0]  data_byte_second_i,
  input logic [4:0]  event_flags_i,
  input logic [3:0]  error_flags_i,
  input logic        start_pending_i,
  input logic        stop_pending_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [10:0] action_flags_o,
  input logic [1:0]  tx_kind_o,
  input logic [7:0]  tx_byte_o,
  input logic        rx_valid_o,
  input logic [5:0]  rx_index_o,
  input logic [7:0]  rx_byte_o,
  input logic        job_accepted_o,
  input logic        busy_res_o,
  input logic        error_o,
  input logic        last_o
);

  // A stalled result holds
  `IMES_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(action_flags_o) && $stable(tx_byte_o) && $stable(rx_byte_o) && $stable(last_o), "stalled result changed")

  // The second result of an item follows straight after the first
  `IMES_ASSERT_NXT(a_second_ready, out_valid_o && out_ready_i && !last_o, out_valid_o && last_o, "second result not ready after first")

  // An accepted job leaves the block busy and clears its error
  `IMES_ASSERT_IMP(a_job_busy, out_valid_o && job_accepted_o, busy_res_o && !error_o && last_o, "accepted job not busy")

  // No received byte, no index or data
  `IMES_ASSERT_IMP(a_rx_zero, out_valid_o && !rx_valid_o, rx_index_o == 6'd0 && rx_byte_o == 8'd0, "rx fields set without rx_valid")

endmodule

bind i2c_master_event_sequencer_top imes_checker u_imes_checker (.*);
